// ===== design/klx_pkg.sv =====
// ============================================================================
// klx_pkg
// Shared types, token kind codes and keyword/symbol tables for the lexer.
// ============================================================================
package klx_pkg;

	localparam int unsigned POS_BITS_DEFAULT    = 16;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam int unsigned LEN_BITS  = 16;
	localparam int unsigned OFS_BITS  = 16;
	localparam int unsigned KIND_BITS = 5;
	localparam int unsigned CHAR_BITS = 8;
	localparam int unsigned NUM_KW    = 5;

	localparam logic [KIND_BITS-1:0] KIND_END     = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_NUM     = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_KW0     = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_SYM0    = 5'd8;
	localparam logic [KIND_BITS-1:0] KIND_INVALID = 5'd19;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT
	} mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OFS_BITS-1:0]  start;
		logic [LEN_BITS-1:0]  len;
		logic [CHAR_BITS-1:0] ch;
	} token_t;

	// Tokens produced by one source character: an optional closed run token
	// followed by an optional end or symbol token.
	typedef struct packed {
		logic   v0;
		token_t tok0;
		logic   v1;
		token_t tok1;
	} record_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Character idx of keyword k (print, if, else, for, to); zero past its end.
	function automatic logic [CHAR_BITS-1:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
		logic [CHAR_BITS-1:0] c;
		c = '0;
		case (k)
			3'd0: begin
				case (idx)
					3'd0: c = "p";
					3'd1: c = "r";
					3'd2: c = "i";
					3'd3: c = "n";
					3'd4: c = "t";
					default: c = '0;
				endcase
			end
			3'd1: begin
				case (idx)
					3'd0: c = "i";
					3'd1: c = "f";
					default: c = '0;
				endcase
			end
			3'd2: begin
				case (idx)
					3'd0: c = "e";
					3'd1: c = "l";
					3'd2: c = "s";
					3'd3: c = "e";
					default: c = '0;
				endcase
			end
			3'd3: begin
				case (idx)
					3'd0: c = "f";
					3'd1: c = "o";
					3'd2: c = "r";
					default: c = '0;
				endcase
			end
			3'd4: begin
				case (idx)
					3'd0: c = "t";
					3'd1: c = "o";
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] n;
		case (k)
			3'd0: n = 3'd5;
			3'd1: n = 3'd2;
			3'd2: n = 3'd4;
			3'd3: n = 3'd3;
			3'd4: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [KIND_BITS-1:0] sym_kind(input logic [CHAR_BITS-1:0] c);
		logic [KIND_BITS-1:0] kd;
		case (c)
			"+": kd = KIND_SYM0 + 5'd0;
			"-": kd = KIND_SYM0 + 5'd1;
			"*": kd = KIND_SYM0 + 5'd2;
			"/": kd = KIND_SYM0 + 5'd3;
			"=": kd = KIND_SYM0 + 5'd4;
			"<": kd = KIND_SYM0 + 5'd5;
			">": kd = KIND_SYM0 + 5'd6;
			"(": kd = KIND_SYM0 + 5'd7;
			")": kd = KIND_SYM0 + 5'd8;
			"{": kd = KIND_SYM0 + 5'd9;
			"}": kd = KIND_SYM0 + 5'd10;
			default: kd = KIND_INVALID;
		endcase
		return kd;
	endfunction

endpackage

// ===== design/klx_front.sv =====
// ============================================================================
// klx_front
// Accepts source characters, tracks the scan state and forms token records.
// ============================================================================
module klx_front import klx_pkg::*; #(
	parameter int unsigned POS_BITS = POS_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CHAR_BITS-1:0] in_char,
	input  logic                 in_end,
	input  queue_status_t        q_status,
	output logic                 push,
	output record_t              push_rec
);

	mode_t                 mode_q, mode_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [POS_BITS-1:0]   start_q, start_d;
	logic [LEN_BITS-1:0]   run_q, run_d;
	logic [NUM_KW-1:0]     cand_q, cand_d;

	logic                  accept;
	logic                  is_end, is_digit, is_alpha, is_space;
	logic [LEN_BITS-1:0]   run_inc;
	logic [POS_BITS+OFS_BITS-1:0] pos_ext, start_ext;
	token_t                pend_tok;
	logic [KIND_BITS-1:0]  ident_kind;
	logic                  kw_found;

	// Keep the keywords that still match at character index run.
	function automatic logic [NUM_KW-1:0] next_mask(input logic [NUM_KW-1:0] cand,
			input logic [LEN_BITS-1:0] run, input logic [CHAR_BITS-1:0] c);
		logic [NUM_KW-1:0] keep;
		keep = '0;
		if (run < LEN_BITS'(5)) begin
			for (int k = 0; k < NUM_KW; k++) begin
				if (cand[k] && (run < {13'b0, kw_len(3'(k))}) && (kw_char(3'(k), run[2:0]) == c))
					keep[k] = 1'b1;
			end
		end
		return keep;
	endfunction

	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign pos_ext   = {{OFS_BITS{1'b0}}, pos_q};
	assign start_ext = {{OFS_BITS{1'b0}}, start_q};
	assign run_inc   = (run_q == {LEN_BITS{1'b1}}) ? run_q : run_q + 1'b1;

	always_comb begin
		is_end   = in_end || (in_char == '0);
		is_digit = (in_char >= "0") && (in_char <= "9");
		is_alpha = ((in_char >= "a") && (in_char <= "z")) ||
		           ((in_char >= "A") && (in_char <= "Z"));
		is_space = (in_char == " ") || ((in_char >= 8'd9) && (in_char <= 8'd13));
	end

	// Kind of the pending identifier: first keyword with a full-length match.
	always_comb begin
		ident_kind = KIND_IDENT;
		kw_found   = 1'b0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (!kw_found && cand_q[i] && (run_q == {13'b0, kw_len(3'(i))})) begin
				ident_kind = KIND_KW0 + KIND_BITS'(i);
				kw_found   = 1'b1;
			end
		end
		pend_tok.kind  = (mode_q == MODE_NUM) ? KIND_NUM : ident_kind;
		pend_tok.start = start_ext[OFS_BITS-1:0];
		pend_tok.len   = run_q;
		pend_tok.ch    = '0;
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		start_d  = start_q;
		run_d    = run_q;
		cand_d   = cand_q;
		push_rec = '0;
		if (is_end) begin
			push_rec.v0        = (mode_q != MODE_IDLE);
			push_rec.tok0      = pend_tok;
			push_rec.v1        = 1'b1;
			push_rec.tok1.kind = KIND_END;
			push_rec.tok1.start = pos_ext[OFS_BITS-1:0];
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			run_d   = '0;
			cand_d  = '0;
		end else begin
			pos_d = pos_q + 1'b1;
			if (mode_q == MODE_NUM && is_digit) begin
				run_d = run_inc;
			end else if (mode_q == MODE_IDENT && (is_alpha || is_digit)) begin
				cand_d = next_mask(cand_q, run_q, in_char);
				run_d  = run_inc;
			end else begin
				push_rec.v0   = (mode_q != MODE_IDLE);
				push_rec.tok0 = pend_tok;
				mode_d = MODE_IDLE;
				cand_d = '0;
				if (is_space) begin
					// Skipped; only a closed run leaves a token.
				end else if (is_digit) begin
					mode_d  = MODE_NUM;
					start_d = pos_q;
					run_d   = LEN_BITS'(1);
				end else if (is_alpha) begin
					mode_d  = MODE_IDENT;
					start_d = pos_q;
					run_d   = LEN_BITS'(1);
					cand_d  = next_mask({NUM_KW{1'b1}}, '0, in_char);
				end else begin
					push_rec.v1         = 1'b1;
					push_rec.tok1.kind  = sym_kind(in_char);
					push_rec.tok1.start = pos_ext[OFS_BITS-1:0];
					push_rec.tok1.len   = LEN_BITS'(1);
					push_rec.tok1.ch    = in_char;
				end
			end
		end
		push = accept && (push_rec.v0 || push_rec.v1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			run_q   <= '0;
			cand_q  <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			run_q   <= run_d;
			cand_q  <= cand_d;
		end
	end

endmodule

// ===== design/klx_queue.sv =====
// ============================================================================
// klx_queue
// Small register queue of token records between the front and back parts.
// ============================================================================
module klx_queue import klx_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  record_t       push_rec,
	input  logic          pop,
	output record_t       head_rec,
	output queue_status_t status
);

	localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	record_t               mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;

	function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/klx_back.sv =====
// ============================================================================
// klx_back
// Unpacks token records into single tokens behind an output register.
// ============================================================================
module klx_back import klx_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  record_t       head_rec,
	input  queue_status_t q_status,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output token_t        out_tok,
	output logic          out_last
);

	logic   phase_q;
	logic   out_valid_q;
	token_t tok_q;
	logic   last_q;

	logic   load;
	logic   sel_second;
	logic   sel_last;
	token_t sel_tok;

	always_comb begin
		load       = !q_status.empty && (!out_valid_q || out_ready);
		sel_second = phase_q || !head_rec.v0;
		sel_tok    = sel_second ? head_rec.tok1 : head_rec.tok0;
		sel_last   = sel_second || !head_rec.v1;
		pop        = load && sel_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= !sel_last;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= sel_tok;
			last_q <= sel_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

endmodule

// ===== design/keyword_token_lexer.sv =====
// ============================================================================
// keyword_token_lexer
// Streaming tokenizer: one source character in, number, identifier, keyword,
// symbol, invalid and end tokens out.
// ============================================================================
//
// Channel  Dir  Beat                     Contents
// s_*      in   one source character     tdata[7:0] char_code, tlast end_of_source
// m_*      out  one token                tuser[4:0] token_kind,
//                                        tdata start_offset, token_length,
//                                        single_char, tlast last_result
//
// The input side takes one character per cycle whenever the record queue has
// room; the front classifies it and updates the scan state in that same cycle.
// Tokens leave at one per cycle while m_tready is high, through a registered
// output; a character that closes a run and also forms a token of its own (or
// ends the source) yields two tokens, which leave the output one after the other.
// The record queue decouples the two sides, so a stalled output backs up into
// the input only after the queue fills.
// Reset clears the scan state, the position, the queue pointers and the
// output valid; there is no clearing pass.
//
module keyword_token_lexer import klx_pkg::*; #(
	parameter int unsigned POS_BITS    = POS_BITS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Source characters.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_source
	// Tokens.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] start_offset, [31:16] token_length,
	                               // [39:32] single_char
	output logic [4:0]  m_tuser,   // [4:0] token_kind
	output logic        m_tlast    // last_result
);

	queue_status_t q_status;
	logic          push;
	record_t       push_rec;
	logic          pop;
	record_t       head_rec;
	token_t        out_tok;

	// Front: classification and the scan state machine.
	klx_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_end   (s_tlast),
		.q_status (q_status),
		.push     (push),
		.push_rec (push_rec)
	);

	// Record queue: one entry per character that produced any token.
	klx_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	// Back: sends the one or two tokens of each record in order.
	klx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_rec  (head_rec),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_tok.kind;
	assign m_tdata = {out_tok.ch, out_tok.len, out_tok.start};

	// An end token always closes the results of its character and has no length.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_END) |-> m_tlast && (m_tdata[31:16] == '0))
		else $error("end token without last flag or with nonzero length");

	// Every token other than the end token covers at least one character.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_END) |-> (m_tdata[31:16] != '0))
		else $error("token of zero length");

	// Runs and the end token carry no character; symbols and invalid ones do.
	a_char_only_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser < KIND_SYM0) |-> (m_tdata[39:32] == '0))
		else $error("character reported on a run or end token");

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full || pop)
		else $error("record queue overflow");

endmodule
